[design/psits_pkg.sv]
`timescale 1ns / 1ps

package psits_pkg;

	localparam int PID_W      = 13;
	localparam int CC_W       = 4;
	localparam int POS_W      = 8;
	localparam int BYTE_W     = 8;
	localparam int WORD_W     = 32;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	localparam logic [POS_W-1:0]  PKT_BYTES     = POS_W'(188);
	localparam logic [POS_W-1:0]  HDR_BYTES     = POS_W'(4);
	localparam logic [POS_W-3:0]  LAST_WORD_IDX = (POS_W-2)'(46);
	localparam logic [BYTE_W-1:0] SYNC_BYTE     = 8'h47;
	localparam logic [BYTE_W-1:0] PAD_BYTE      = 8'hFF;
	localparam logic [BYTE_W-1:0] PTR_BYTE      = 8'h00;
	localparam logic [3:0]        AFC_PAYLOAD   = 4'h1;

	// register index, taken from paddr above the byte offset
	localparam logic REG_STREAM_PID = 1'b0;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_HDR,
		OP_BYTE,
		OP_PAD
	} dp_op_t;

	typedef struct packed {
		logic pos_zero;
		logic byte_closes;
		logic pad_closes;
		logic out_free;
	} dp_status_t;

endpackage

[design/psits_dp.sv]
`timescale 1ns / 1ps

module psits_dp
	import psits_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  dp_op_t            op,
	input  logic [PID_W-1:0]  pid,
	input  logic [BYTE_W-1:0] section_byte,
	input  logic              section_end,
	output dp_status_t        status,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [WORD_W-1:0] packet_word,
	output logic              packet_last
);

	logic [CC_W-1:0]   cc_q;
	logic              open_q;
	logic [POS_W-1:0]  pos_q;
	logic [23:0]       buf_q;
	logic              valid_q;
	logic [WORD_W-1:0] word_q;
	logic              last_q;

	logic              emit;
	logic [WORD_W-1:0] word_d;
	logic              last_d;
	logic [CC_W-1:0]   cc_inc;
	logic              byte_closes;
	logic              pad_closes;

	assign cc_inc      = cc_q + CC_W'(1);
	assign byte_closes = (pos_q == PKT_BYTES - POS_W'(1));
	assign pad_closes  = (pos_q[POS_W-1:2] == LAST_WORD_IDX);

	always_comb begin
		emit   = 1'b0;
		word_d = {buf_q, section_byte};
		last_d = 1'b0;
		case (op)
			OP_HDR: begin
				emit   = 1'b1;
				word_d = {SYNC_BYTE, 1'b0, ~open_q, 1'b0, pid[12:8], pid[7:0],
					AFC_PAYLOAD, cc_inc};
			end
			OP_BYTE: begin
				emit   = (pos_q[1:0] == 2'd3);
				last_d = byte_closes;
			end
			OP_PAD: begin
				emit   = 1'b1;
				last_d = pad_closes;
				// fill the rest of the current word with stuffing
				case (pos_q[1:0])
					2'd0:    word_d = {4{PAD_BYTE}};
					2'd1:    word_d = {buf_q[7:0], {3{PAD_BYTE}}};
					2'd2:    word_d = {buf_q[15:0], {2{PAD_BYTE}}};
					default: word_d = {buf_q[23:0], PAD_BYTE};
				endcase
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q    <= '0;
			open_q  <= 1'b0;
			pos_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (emit) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
			case (op)
				OP_HDR: begin
					cc_q   <= cc_inc;
					open_q <= 1'b1;
					// the first byte rides along, behind the pointer byte on a new section
					pos_q  <= HDR_BYTES + (open_q ? POS_W'(1) : POS_W'(2));
				end
				OP_BYTE: begin
					pos_q <= byte_closes ? '0 : pos_q + POS_W'(1);
					if (section_end && byte_closes) begin
						open_q <= 1'b0;
					end
				end
				OP_PAD: begin
					pos_q <= pad_closes ? '0 : {pos_q[POS_W-1:2] + (POS_W-2)'(1), 2'b00};
					if (pad_closes) begin
						open_q <= 1'b0;
					end
				end
				default: begin
					pos_q <= pos_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_HDR:  buf_q <= open_q ? {buf_q[15:0], section_byte}
				: {buf_q[7:0], PTR_BYTE, section_byte};
			OP_BYTE: buf_q <= {buf_q[15:0], section_byte};
			default: buf_q <= buf_q;
		endcase
		if (emit) begin
			word_q <= word_d;
			last_q <= last_d;
		end
	end

	assign status.pos_zero    = (pos_q == '0);
	assign status.byte_closes = byte_closes;
	assign status.pad_closes  = pad_closes;
	assign status.out_free    = !valid_q || out_ready;

	assign out_valid   = valid_q;
	assign packet_word = word_q;
	assign packet_last = last_q;

`ifndef ASSERT_OFF
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (!valid_q || out_ready))
		else $error("word produced while output register is full");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q < PKT_BYTES)
		else $error("packet position out of range");

	a_hdr_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_HDR) |-> (pos_q == '0))
		else $error("header started inside a packet");

	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && last_d) |=> (pos_q == '0))
		else $error("packet end word did not close the packet");
`endif

endmodule

[design/psits_ctrl.sv]
`timescale 1ns / 1ps

module psits_ctrl
	import psits_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       section_end,
	output logic       in_ready,
	input  dp_status_t status,
	output dp_op_t     op
);

	typedef enum logic {
		S_IDLE,
		S_PAD
	} state_t;

	state_t state_q;

	always_comb begin
		op       = OP_NONE;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = status.out_free;
				// a request with no packet open also puts out the header word
				if (in_valid && status.out_free) begin
					op = status.pos_zero ? OP_HDR : OP_BYTE;
				end
			end
			S_PAD: begin
				if (status.out_free) begin
					op = OP_PAD;
				end
			end
			default: begin
				op = OP_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (op == OP_HDR && section_end) begin
						state_q <= S_PAD;
					end else if (op == OP_BYTE && section_end && !status.byte_closes) begin
						state_q <= S_PAD;
					end
				end
				S_PAD: begin
					if (op == OP_PAD && status.pad_closes) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[design/psi_section_ts_packetizer.sv]
`timescale 1ns / 1ps

// Packs PSI section bytes into 188-byte transport packets, sent as big-endian
// 32-bit words, 47 per packet, with packet_last on the final word. The byte that
// opens a packet is taken like any other, and its header word goes to the
// output register in the same cycle as that byte; on the first packet of a section
// the zero pointer byte is slotted in with it, so data streams at one byte per
// cycle. After the last byte of a section the packet is stuffed with 0xFF one
// word per cycle while input is held off. All of this is paced by the single
// output register: while it is full and not taken, the sequencer waits. The
// continuity counter runs on across sections; stream_pid sits at byte address 0
// and should be written while idle.
module psi_section_ts_packetizer
	import psits_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [BYTE_W-1:0]     section_byte,
	input  logic                  section_end,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [WORD_W-1:0]     packet_word,
	output logic                  packet_last
);

	logic [PID_W-1:0] pid_q;
	dp_op_t           op;
	dp_status_t       status;
	logic             reg_sel;

	assign reg_sel = (paddr[2] == REG_STREAM_PID);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pid_q <= '0;
		end else if (psel && penable && pwrite && reg_sel) begin
			pid_q <= pwdata[PID_W-1:0];
		end
	end

	assign prdata = reg_sel ? {{(APB_DATA_W-PID_W){1'b0}}, pid_q} : '0;

	psits_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.section_end (section_end),
		.in_ready    (in_ready),
		.status      (status),
		.op          (op)
	);

	psits_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (op),
		.pid          (pid_q),
		.section_byte (section_byte),
		.section_end  (section_end),
		.status       (status),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.packet_word  (packet_word),
		.packet_last  (packet_last)
	);

endmodule

[verif/psi_section_ts_packetizer_tb.sv]
`timescale 1ns / 1ps

module psi_section_ts_packetizer_tb;
	import psits_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_COUNT = 4;
	localparam int PHASE_BYTES = 25;
	localparam int ROW_COUNT = 17;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              last;
	} ts_word_t;

	typedef struct packed {
		logic              set_pid;
		logic [31:0]       pid_value;
		logic [BYTE_W-1:0] sbyte;
		logic              closes;
		logic              pinned;
		logic [WORD_W-1:0] pinned_word;
	} stim_row_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_CHOKED,
		RX_PERIODIC
	} rx_mode_t;

	// header word typed in wherever a row opens a packet
	localparam stim_row_t DIRECTED [ROW_COUNT] = '{
		'{1'b0, 32'h0000_0000, 8'h00, 1'b1, 1'b1, 32'h4740_0011},
		'{1'b0, 32'h0000_0000, 8'hFF, 1'b1, 1'b1, 32'h4740_0012},
		'{1'b1, 32'hFFFF_FFFF, 8'h80, 1'b0, 1'b1, 32'h475F_FF13},
		'{1'b0, 32'h0000_0000, 8'h01, 1'b0, 1'b0, 32'h0},
		'{1'b0, 32'h0000_0000, 8'h7F, 1'b0, 1'b0, 32'h0},
		'{1'b0, 32'h0000_0000, 8'hFE, 1'b1, 1'b0, 32'h0},
		'{1'b1, 32'h0000_1555, 8'h55, 1'b0, 1'b1, 32'h4755_5514},
		'{1'b0, 32'h0000_0000, 8'hAA, 1'b0, 1'b0, 32'h0},
		'{1'b0, 32'h0000_0000, 8'h33, 1'b1, 1'b0, 32'h0},
		'{1'b1, 32'h0000_0AAA, 8'hC3, 1'b1, 1'b1, 32'h474A_AA15},
		'{1'b0, 32'h0000_0000, 8'h11, 1'b0, 1'b1, 32'h474A_AA16},
		'{1'b0, 32'h0000_0000, 8'h22, 1'b0, 1'b0, 32'h0},
		'{1'b0, 32'h0000_0000, 8'h44, 1'b0, 1'b0, 32'h0},
		'{1'b0, 32'h0000_0000, 8'h88, 1'b0, 1'b0, 32'h0},
		'{1'b0, 32'h0000_0000, 8'h0F, 1'b0, 1'b0, 32'h0},
		'{1'b0, 32'h0000_0000, 8'hF0, 1'b0, 1'b0, 32'h0},
		'{1'b0, 32'h0000_0000, 8'h3C, 1'b1, 1'b0, 32'h0}
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [BYTE_W-1:0]     section_byte = '0;
	logic                  section_end = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [WORD_W-1:0]     packet_word;
	logic                  packet_last;

	// packetizer shadow state
	ts_word_t          words_due[$];
	logic [PID_W-1:0]  pid_shadow = '0;
	logic [CC_W-1:0]   cc_shadow = '0;
	logic              open_shadow = 1'b0;
	logic [POS_W-1:0]  pos_shadow = '0;
	logic [23:0]       gather = '0;
	logic [1:0]        gather_cnt = '0;

	logic              pin_on = 1'b0;
	logic [WORD_W-1:0] pin_word = '0;
	ts_word_t          due;
	int                mark;
	int                fail_count = 0;
	int                cycle_count = 0;
	int                burst_left = 0;
	rx_mode_t          rx_mode = RX_OPEN;
	int                rx_span = 0;
	int                row_i;
	int                phase;
	int                phase_bytes;
	int                sec_len;
	int                k;
	logic [31:0]       rnd;

	psi_section_ts_packetizer dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.section_byte(section_byte),
		.section_end(section_end),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.packet_word(packet_word),
		.packet_last(packet_last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void emit_stream_byte(logic [BYTE_W-1:0] b);
		logic is_last;
		pos_shadow = pos_shadow + POS_W'(1);
		is_last = (pos_shadow >= PKT_BYTES);
		if (is_last)
			pos_shadow = '0;
		if (gather_cnt == 2'd3) begin
			words_due.push_back('{word: {gather, b}, last: is_last});
			gather = '0;
			gather_cnt = '0;
		end else begin
			gather = {gather[15:0], b};
			gather_cnt = gather_cnt + 2'd1;
		end
	endfunction

	function automatic void packetize_byte(logic [BYTE_W-1:0] b, logic closes);
		logic opening;
		opening = !open_shadow;
		if (pos_shadow == '0) begin
			cc_shadow = cc_shadow + CC_W'(1);
			gather = '0;
			gather_cnt = '0;
			emit_stream_byte(SYNC_BYTE);
			emit_stream_byte({1'b0, opening, 1'b0, pid_shadow[12:8]});
			emit_stream_byte(pid_shadow[7:0]);
			emit_stream_byte({AFC_PAYLOAD, cc_shadow});
			if (opening) begin
				open_shadow = 1'b1;
				emit_stream_byte(PTR_BYTE);
			end
		end
		emit_stream_byte(b);
		if (closes) begin
			while (pos_shadow != '0)
				emit_stream_byte(PAD_BYTE);
			open_shadow = 1'b0;
			gather = '0;
			gather_cnt = '0;
		end
	endfunction

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				mark = words_due.size();
				packetize_byte(section_byte, section_end);
				if (pin_on && words_due.size() > mark)
					words_due[mark].word = pin_word;
			end
			if (out_valid && out_ready) begin
				if (words_due.size() == 0) begin
					$error("packet_word %h arrived with nothing pending", packet_word);
					fail_count++;
				end else begin
					due = words_due.pop_front();
					if (packet_word !== due.word) begin
						$error("packet_word: expected %h, got %h", due.word, packet_word);
						fail_count++;
					end
					if (packet_last !== due.last) begin
						$error("packet_last: expected %b, got %b", due.last, packet_last);
						fail_count++;
					end
				end
			end
		end
	end

	// receiver back-pressure, switching between patterns
	always @(negedge clk) begin
		if (rx_span == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_span = $urandom_range(20, 300);
		end
		rx_span--;
		case (rx_mode)
			RX_OPEN: out_ready = 1'b1;
			RX_COIN: out_ready = ($urandom_range(0, 1) == 1);
			RX_CHOKED: out_ready = ($urandom_range(0, 7) == 0);
			default: out_ready = (cycle_count % 5 != 0);
		endcase
	end

	task automatic send_section_byte(input logic [BYTE_W-1:0] b, input logic closes);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 5);
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
			burst_left = $urandom_range(1, 30);
		end
		in_valid = 1'b1;
		section_byte = b;
		section_end = closes;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		burst_left--;
	endtask

	// hold input until every packet word is out, then let the pipe settle
	task automatic settle_idle();
		in_valid = 1'b0;
		while (words_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic check_pid_readback();
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = {REG_STREAM_PID, 2'b00};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[PID_W-1:0] !== pid_shadow) begin
			$error("stream_pid: expected %h, got %h", pid_shadow, prdata[PID_W-1:0]);
			fail_count++;
		end
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic write_pid(input logic [31:0] value);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {REG_STREAM_PID, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		pid_shadow = value[PID_W-1:0];
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		check_pid_readback();
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		check_pid_readback();

		for (row_i = 0; row_i < ROW_COUNT; row_i++) begin
			if (DIRECTED[row_i].set_pid) begin
				settle_idle();
				write_pid(DIRECTED[row_i].pid_value);
			end
			pin_on = DIRECTED[row_i].pinned;
			pin_word = DIRECTED[row_i].pinned_word;
			send_section_byte(DIRECTED[row_i].sbyte, DIRECTED[row_i].closes);
			pin_on = 1'b0;
		end

		for (phase = 0; phase < PHASE_COUNT; phase++) begin
			settle_idle();
			rnd = $urandom;
			case (phase)
				0: write_pid({rnd[31:PID_W], {PID_W{1'b0}}});
				1: write_pid({rnd[31:PID_W], {PID_W{1'b1}}});
				default: write_pid(rnd);
			endcase
			phase_bytes = 0;
			while (phase_bytes < PHASE_BYTES) begin
				// one section that fills its first packet exactly
				if (phase == 1 && phase_bytes == 0)
					sec_len = 183;
				else
					sec_len = $urandom_range(1, 8);
				for (k = 1; k <= sec_len; k++)
					send_section_byte(BYTE_W'($urandom_range(0, 255)), k == sec_len);
				phase_bytes += sec_len;
			end
		end

		settle_idle();
		repeat (20) @(negedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
